@@ rtl/hfr_pkg.sv @@
// Package for the hashed frame receiver: shared constants, result codes and
// the command and status structs that pass between controller and datapath.
// No dependencies.
`default_nettype none

package hfr_pkg;

  // Fixed widths of the frame fields.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned HASH_W = 16;
  localparam int unsigned STAT_W = 3;

  // Framing characters.
  localparam logic [BYTE_W-1:0] START_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'hFE;
  localparam logic [BYTE_W-1:0] STOP_CHAR  = 8'h2E;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_LEN_ERR  = 3'd1;
  localparam logic [STAT_W-1:0] ST_HASH_ERR = 3'd2;
  localparam logic [STAT_W-1:0] ST_RCPT_ERR = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_OWN_ID   = 1'b0;
  localparam logic CFG_BCAST_ID = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              start;        // open a new frame
    logic              take;         // store one frame byte
    logic              rd_start;     // read message byte 0
    logic              rd_next;      // read the following message byte
    logic              code_load;    // capture the message code
    logic              cur_load;     // hold the byte just read as content
    logic              out_load;     // load the output register
    logic [STAT_W-1:0] out_status;
    logic              out_content;
    logic              out_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic idx_full;
    logic len_ok;
    logic hash_ok;
    logic rcpt_ok;
    logic rd_content;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/hfr_datapath.sv @@
// Datapath of the hashed frame receiver: frame registers, running hash,
// message memory, configuration registers and the output register.
// Depends on hfr_pkg.
`default_nettype none

module hfr_datapath #(
  parameter int unsigned MAX_FRAME   = 32,
  parameter int unsigned MAX_CONTENT = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  cfg_data,
  input  wire logic                        out_stall,
  input  wire hfr_pkg::ctl_cmd_t           cmd,
  output hfr_pkg::dp_status_t              status,
  output logic                             out_valid,
  output logic [hfr_pkg::STAT_W-1:0]       out_status,
  output logic [hfr_pkg::BYTE_W-1:0]       out_sender,
  output logic [hfr_pkg::BYTE_W-1:0]       out_msg_code,
  output logic [hfr_pkg::BYTE_W-1:0]       out_content_byte,
  output logic                             out_content_valid,
  output logic                             out_last
);

  // Only frames of at most MAX_FRAME-1 bytes can pass the length check,
  // so the message never needs more than MAX_FRAME-7 entries.
  localparam int unsigned DEPTH = MAX_FRAME - 7;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [hfr_pkg::IDX_W-1:0] IDX_LIMIT = hfr_pkg::IDX_W'(MAX_FRAME - 1);
  localparam logic [hfr_pkg::IDX_W-1:0] DEPTH_IDX = hfr_pkg::IDX_W'(DEPTH);
  localparam logic [hfr_pkg::IDX_W:0]   CONT_LIM  = (hfr_pkg::IDX_W + 1)'(MAX_CONTENT);

  // Configuration registers.
  logic [hfr_pkg::BYTE_W-1:0] own_id_r;
  logic [hfr_pkg::BYTE_W-1:0] bcast_id_r;

  // Frame registers.
  logic [hfr_pkg::IDX_W-1:0]  byte_index_r;
  logic [hfr_pkg::BYTE_W-1:0] frame_len_r;
  logic [hfr_pkg::BYTE_W-1:0] sender_r;
  logic [hfr_pkg::BYTE_W-1:0] rcpt_r;
  logic [hfr_pkg::HASH_W-1:0] hash_r;
  logic                       hash_stop_r;
  logic [hfr_pkg::HASH_W-1:0] rx_hash_r;

  // Message memory and its read side.
  logic [hfr_pkg::BYTE_W-1:0] msg_mem [DEPTH];
  logic [hfr_pkg::BYTE_W-1:0] rdata_r;
  logic [hfr_pkg::IDX_W-1:0]  ptr_r;
  logic [hfr_pkg::BYTE_W-1:0] code_r;
  logic [hfr_pkg::BYTE_W-1:0] cur_r;

  // Output register.
  logic                       out_valid_r;
  logic [hfr_pkg::STAT_W-1:0] out_status_r;
  logic [hfr_pkg::BYTE_W-1:0] out_sender_r;
  logic [hfr_pkg::BYTE_W-1:0] out_code_r;
  logic [hfr_pkg::BYTE_W-1:0] out_cbyte_r;
  logic                       out_cvalid_r;
  logic                       out_last_r;

  logic [hfr_pkg::IDX_W-1:0]  msg_k;
  logic [hfr_pkg::IDX_W-1:0]  ptr_inc;
  logic [AW-1:0]              rd_addr;
  logic                       in_message;
  logic                       hash_span;
  logic [hfr_pkg::HASH_W-1:0] hash_nxt;
  logic                       ok_result;

  // Position of the current byte inside the message and hash fields.
  assign msg_k      = byte_index_r - hfr_pkg::IDX_W'(4);
  assign in_message = ({2'b00, msg_k} < frame_len_r);
  assign hash_span  = (byte_index_r < hfr_pkg::IDX_W'(4)) || in_message;
  assign hash_nxt   = (hash_r + {hash_r[hfr_pkg::HASH_W-6:0], 5'b00000})
                      ^ {8'h00, rx_byte};

  // Next read address, held inside the memory range.
  assign ptr_inc = ptr_r + hfr_pkg::IDX_W'(1);
  assign rd_addr = (ptr_inc < DEPTH_IDX) ? ptr_inc[AW-1:0] : '0;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      bcast_id_r <= 8'hFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hfr_pkg::CFG_OWN_ID:   own_id_r   <= cfg_data;
        hfr_pkg::CFG_BCAST_ID: bcast_id_r <= cfg_data;
        default:               own_id_r   <= own_id_r;
      endcase
    end
  end

  // Frame header, received hash and running hash.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      frame_len_r  <= '0;
      sender_r     <= '0;
      rcpt_r       <= '0;
      hash_r       <= '0;
      hash_stop_r  <= 1'b0;
      rx_hash_r    <= '0;
    end else if (cmd.start) begin
      byte_index_r <= hfr_pkg::IDX_W'(1);
      frame_len_r  <= '0;
      sender_r     <= '0;
      rcpt_r       <= '0;
      hash_r       <= {8'h00, hfr_pkg::START_MARK};
      hash_stop_r  <= 1'b0;
      rx_hash_r    <= '0;
    end else if (cmd.take) begin
      if (byte_index_r == hfr_pkg::IDX_W'(1)) begin
        frame_len_r <= rx_byte;
      end else if (byte_index_r == hfr_pkg::IDX_W'(2)) begin
        sender_r <= rx_byte;
      end else if (byte_index_r == hfr_pkg::IDX_W'(3)) begin
        rcpt_r <= rx_byte;
      end else if (!in_message) begin
        if ({2'b00, msg_k} == frame_len_r) begin
          rx_hash_r[7:0] <= rx_byte;
        end else if ({3'b000, msg_k} == ({1'b0, frame_len_r} + 9'd1)) begin
          rx_hash_r[15:8] <= rx_byte;
        end
      end
      // The hash stops for good at the first zero byte of the header or message.
      if (!hash_stop_r && hash_span) begin
        if (rx_byte == '0) begin
          hash_stop_r <= 1'b1;
        end else begin
          hash_r <= hash_nxt;
        end
      end
      byte_index_r <= byte_index_r + hfr_pkg::IDX_W'(1);
    end
  end

  // Message memory write.
  always_ff @(posedge clk) begin
    if (cmd.take && (byte_index_r >= hfr_pkg::IDX_W'(4)) && in_message
        && (msg_k < DEPTH_IDX)) begin
      msg_mem[msg_k[AW-1:0]] <= rx_byte;
    end
  end

  // Message memory read, one byte per step.
  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      rdata_r <= msg_mem[0];
      ptr_r   <= '0;
    end else if (cmd.rd_next) begin
      rdata_r <= msg_mem[rd_addr];
      ptr_r   <= ptr_inc;
    end
    if (cmd.code_load) begin
      code_r <= (frame_len_r == '0) ? '0 : rdata_r;
    end
    if (cmd.cur_load) begin
      cur_r <= rdata_r;
    end
  end

  // Output register: cleared by a transfer, loaded by the controller.
  assign ok_result = (cmd.out_status == hfr_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_sender_r <= ok_result ? sender_r : '0;
      out_code_r   <= ok_result ? code_r : '0;
      out_cbyte_r  <= cmd.out_content ? cur_r : '0;
      out_cvalid_r <= cmd.out_content;
      out_last_r   <= cmd.out_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.is_start   = (rx_byte == hfr_pkg::START_MARK);
    status.is_end     = (rx_byte == hfr_pkg::END_MARK);
    status.idx_full   = (byte_index_r >= IDX_LIMIT);
    status.len_ok     = ({3'b000, byte_index_r} == ({1'b0, frame_len_r} + 9'd6));
    status.hash_ok    = (hash_r == rx_hash_r);
    status.rcpt_ok    = (rcpt_r == own_id_r) || (rcpt_r == bcast_id_r);
    status.rd_content = ({2'b00, ptr_r} < frame_len_r)
                        && ({1'b0, ptr_r} <= CONT_LIM)
                        && (rdata_r != hfr_pkg::STOP_CHAR);
    status.out_busy   = out_valid_r;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_sender        = out_sender_r;
  assign out_msg_code      = out_code_r;
  assign out_content_byte  = out_cbyte_r;
  assign out_content_valid = out_cvalid_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

@@ rtl/hfr_ctrl.sv @@
// Controller of the hashed frame receiver: hunts for frames, sequences the
// checks at the end byte and steps through the message content.
// Depends on hfr_pkg.
`default_nettype none

module hfr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                out_stall,
  input  wire hfr_pkg::dp_status_t status,
  output hfr_pkg::ctl_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_COLLECT,
    S_CODE,
    S_FIRST,
    S_NEXT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_free;
  logic   in_xfer;

  // The output register can take a result when empty or being drained.
  assign out_free = !status.out_busy || !out_stall;
  assign in_stall = !((state_r == S_HUNT) || ((state_r == S_COLLECT) && out_free));
  assign in_xfer  = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HUNT: begin
        if (in_xfer && status.is_start) begin
          cmd.start = 1'b1;
          state_nxt = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (in_xfer) begin
          if (status.is_end) begin
            state_nxt      = S_HUNT;
            cmd.out_last   = 1'b1;
            cmd.out_load   = 1'b1;
            if (!status.len_ok) begin
              cmd.out_status = hfr_pkg::ST_LEN_ERR;
            end else if (!status.hash_ok) begin
              cmd.out_status = hfr_pkg::ST_HASH_ERR;
            end else if (!status.rcpt_ok) begin
              cmd.out_status = hfr_pkg::ST_RCPT_ERR;
            end else begin
              cmd.out_load = 1'b0;
              cmd.rd_start = 1'b1;
              state_nxt    = S_CODE;
            end
          end else if (status.idx_full) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = hfr_pkg::ST_OVERFLOW;
            cmd.out_last   = 1'b1;
            state_nxt      = S_HUNT;
          end else begin
            cmd.take = 1'b1;
          end
        end
      end
      S_CODE: begin
        cmd.code_load = 1'b1;
        cmd.rd_next   = 1'b1;
        state_nxt     = S_FIRST;
      end
      S_FIRST: begin
        if (status.rd_content) begin
          cmd.cur_load = 1'b1;
          cmd.rd_next  = 1'b1;
          state_nxt    = S_NEXT;
        end else if (out_free) begin
          // A message without content gives a single result.
          cmd.out_load   = 1'b1;
          cmd.out_status = hfr_pkg::ST_OK;
          cmd.out_last   = 1'b1;
          state_nxt      = S_HUNT;
        end
      end
      S_NEXT: begin
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = hfr_pkg::ST_OK;
          cmd.out_content = 1'b1;
          cmd.out_last    = !status.rd_content;
          if (status.rd_content) begin
            cmd.cur_load = 1'b1;
            cmd.rd_next  = 1'b1;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hashed_frame_receiver.sv @@
// Top level of the hashed frame receiver: joins the controller and datapath.
// Depends on hfr_pkg, hfr_ctrl and hfr_datapath.
//
// Usage: received link bytes enter on in_rx_byte with in_valid; a transfer
// happens when in_valid is high and in_stall is low. Frames start with 0xFF
// and end with 0xFE; other bytes outside a frame are dropped. Results leave on
// the out_ channel, one per transfer, with out_last on the final result of a
// frame. own_id and broadcast_id are written through cfg_wr_en, cfg_index and
// cfg_data while the block is idle.
// Throughput: one byte per cycle while hunting or collecting. An error result
// is in the output register in the cycle after the end byte or the overflowing
// byte. A good frame steps through S_CODE and S_FIRST and loads its first result
// in S_NEXT (in S_FIRST when it has no content bytes), then gives one result per
// cycle while the output is not stalled; the input stalls from the end byte
// until the last result has been loaded, since the message memory is read one
// byte per step. While a frame is collected, a byte is taken only when the
// output register is free, so a stalled receiver also stalls the link.
// Reset (rst_n low, synchronous) empties the output register, restores the
// register defaults (own_id 0, broadcast_id 255) and starts hunting.
`default_nettype none

module hashed_frame_receiver #(
  parameter int unsigned MAX_FRAME   = 32,
  parameter int unsigned MAX_CONTENT = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [hfr_pkg::STAT_W-1:0]       out_status,
  output logic [hfr_pkg::BYTE_W-1:0]       out_sender,
  output logic [hfr_pkg::BYTE_W-1:0]       out_msg_code,
  output logic [hfr_pkg::BYTE_W-1:0]       out_content_byte,
  output logic                             out_content_valid,
  output logic                             out_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [hfr_pkg::BYTE_W-1:0]  cfg_data
);

  hfr_pkg::ctl_cmd_t   cmd;
  hfr_pkg::dp_status_t status;

  // Controller.
  hfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  hfr_datapath #(
    .MAX_FRAME   (MAX_FRAME),
    .MAX_CONTENT (MAX_CONTENT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_byte           (in_rx_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_sender        (out_sender),
    .out_msg_code      (out_msg_code),
    .out_content_byte  (out_content_byte),
    .out_content_valid (out_content_valid),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/hfr_checker.sv @@
// Port-level checker for the hashed frame receiver and its bind statement.
// Depends on hfr_pkg and the hashed_frame_receiver top level.
`default_nettype none

module hfr_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [hfr_pkg::STAT_W-1:0] out_status,
  input wire logic [hfr_pkg::BYTE_W-1:0] out_sender,
  input wire logic [hfr_pkg::BYTE_W-1:0] out_msg_code,
  input wire logic [hfr_pkg::BYTE_W-1:0] out_content_byte,
  input wire logic                       out_content_valid,
  input wire logic                       out_last
);

  // A stalled result stays in place until its transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_content_byte) && $stable(out_last))
    else $error("stalled result changed");

  // An error result is a single, final result with cleared fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != hfr_pkg::ST_OK) |-> out_last && !out_content_valid
      && (out_sender == '0) && (out_msg_code == '0) && (out_content_byte == '0))
    else $error("error result carries data");

  // A result without content closes its frame and shows a zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_content_valid |-> out_last && (out_content_byte == '0))
    else $error("empty result not final");

  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == hfr_pkg::ST_OK) || (out_status == hfr_pkg::ST_LEN_ERR)
      || (out_status == hfr_pkg::ST_HASH_ERR) || (out_status == hfr_pkg::ST_RCPT_ERR)
      || (out_status == hfr_pkg::ST_OVERFLOW))
    else $error("undefined status code");

endmodule

bind hashed_frame_receiver hfr_checker u_hfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_sender        (out_sender),
  .out_msg_code      (out_msg_code),
  .out_content_byte  (out_content_byte),
  .out_content_valid (out_content_valid),
  .out_last          (out_last)
);

`default_nettype wire

@@ dv/tb_hashed_frame_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking bench for hashed_frame_receiver: directed and random link bytes
// against an in-bench model of the deframer, with random flow control on both
// sides. Depends on hfr_pkg and the hashed_frame_receiver RTL.

module tb_hashed_frame_receiver;

  localparam int FRAME_CAP   = 32;
  localparam int CONTENT_CAP = 24;
  localparam int HALF_PERIOD = 5;
  localparam int PHASES      = 4;
  localparam int PHASE_BYTES = 68;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_LEN    = 80;

  // Station ids per phase; phase 0 keeps the reset values.
  localparam logic [PHASES-1:0][7:0] OWN_TBL   = {8'h01, 8'h3C, 8'hFF, 8'h00};
  localparam logic [PHASES-1:0][7:0] BCAST_TBL = {8'h01, 8'hA5, 8'h00, 8'hFF};

  typedef struct packed {
    logic [hfr_pkg::STAT_W-1:0] status;
    logic [7:0]                 sender;
    logic [7:0]                 msg_code;
    logic [7:0]                 content_byte;
    logic                       content_valid;
    logic                       last;
  } frame_result_t;

  typedef logic [7:0] byte_list_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [hfr_pkg::STAT_W-1:0] out_status;
  logic [7:0] out_sender;
  logic [7:0] out_msg_code;
  logic [7:0] out_content_byte;
  logic       out_content_valid;
  logic       out_last;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = hfr_pkg::CFG_OWN_ID;
  logic [7:0] cfg_data = 8'h00;

  // Link bytes waiting to be offered and results the deframer still owes.
  byte_list_t      link_bytes;
  frame_result_t   due_reports[$];
  int              bytes_pushed = 0;
  int              bytes_taken = 0;
  int              error_count = 0;
  logic            link_fired = 1'b0;
  logic            report_fired = 1'b0;

  // Flow-control state of the two sides.
  int              send_wait = 0;
  int              recv_wait = 0;
  bit              send_quiet = 1'b0;
  bit              recv_quiet = 1'b0;
  int              hold_left = 0;
  bit              hold_used = 1'b0;

  // Deframer state as the bench tracks it.
  logic            rx_collecting;
  logic [5:0]      rx_index;
  logic [7:0]      rx_len;
  logic [7:0]      rx_sender;
  logic [7:0]      rx_rcpt;
  logic [15:0]     rx_hash;
  logic            rx_hash_off;
  logic [15:0]     rx_got_hash;
  logic [7:0]      msg_mem[FRAME_CAP];
  logic [7:0]      id_own;
  logic [7:0]      id_bcast;

  hashed_frame_receiver #(
    .MAX_FRAME  (FRAME_CAP),
    .MAX_CONTENT(CONTENT_CAP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_sender       (out_sender),
    .out_msg_code     (out_msg_code),
    .out_content_byte (out_content_byte),
    .out_content_valid(out_content_valid),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Random wait length, with occasional stretches of no waiting at all.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic string show(frame_result_t r);
    return $sformatf("st=%0d snd=%02h code=%02h byte=%02h cv=%0b last=%0b",
                     r.status, r.sender, r.msg_code, r.content_byte,
                     r.content_valid, r.last);
  endfunction

  // Queue the single result of a rejected frame.
  function automatic void reject_frame(logic [hfr_pkg::STAT_W-1:0] code);
    frame_result_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    due_reports.push_back(r);
  endfunction

  // The end byte arrived: check length, hash and recipient, then emit content.
  function automatic void close_frame();
    frame_result_t r;
    int n;
    rx_collecting = 1'b0;
    if (int'(rx_index) != 6 + int'(rx_len)) begin
      reject_frame(hfr_pkg::ST_LEN_ERR);
      return;
    end
    if (rx_hash != rx_got_hash) begin
      reject_frame(hfr_pkg::ST_HASH_ERR);
      return;
    end
    if (rx_rcpt != id_own && rx_rcpt != id_bcast) begin
      reject_frame(hfr_pkg::ST_RCPT_ERR);
      return;
    end
    r = '0;
    r.status = hfr_pkg::ST_OK;
    r.sender = rx_sender;
    r.msg_code = (rx_len > 0) ? msg_mem[0] : 8'h00;
    n = 0;
    while (n < CONTENT_CAP && n + 1 < int'(rx_len) && n + 1 < FRAME_CAP &&
           msg_mem[n + 1] != hfr_pkg::STOP_CHAR)
      n++;
    if (n == 0) begin
      r.last = 1'b1;
      due_reports.push_back(r);
      return;
    end
    for (int i = 0; i < n; i++) begin
      r.content_byte = msg_mem[i + 1];
      r.content_valid = 1'b1;
      r.last = (i + 1 == n);
      due_reports.push_back(r);
    end
  endfunction

  // Advance the deframer by one accepted link byte.
  function automatic void track_link_byte(logic [7:0] b);
    int k;
    if (!rx_collecting) begin
      if (b == hfr_pkg::START_MARK) begin
        rx_collecting = 1'b1;
        rx_index = 6'd1;
        rx_hash = {8'h00, hfr_pkg::START_MARK};
        rx_hash_off = 1'b0;
        rx_len = 8'h00;
        rx_sender = 8'h00;
        rx_rcpt = 8'h00;
        rx_got_hash = 16'h0000;
      end
      return;
    end
    if (b == hfr_pkg::END_MARK) begin
      close_frame();
      return;
    end
    if (int'(rx_index) >= FRAME_CAP - 1) begin
      rx_collecting = 1'b0;
      reject_frame(hfr_pkg::ST_OVERFLOW);
      return;
    end
    case (rx_index)
      6'd1: rx_len = b;
      6'd2: rx_sender = b;
      6'd3: rx_rcpt = b;
      default: begin
        k = int'(rx_index) - 4;
        if (k < int'(rx_len) && k < FRAME_CAP) msg_mem[k] = b;
        else if (k == int'(rx_len)) rx_got_hash[7:0] = b;
        else if (k == int'(rx_len) + 1) rx_got_hash[15:8] = b;
      end
    endcase
    // The hash covers header and message and freezes at the first zero byte.
    if (!rx_hash_off && (rx_index < 6'd4 || int'(rx_index) - 4 < int'(rx_len))) begin
      if (b == 8'h00) rx_hash_off = 1'b1;
      else rx_hash = 16'((rx_hash * 33) ^ b);
    end
    rx_index = rx_index + 6'd1;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    link_bytes.push_back(b);
    bytes_pushed++;
  endfunction

  // Any byte value except the end mark.
  function automatic logic [7:0] rand_field();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hfr_pkg::END_MARK);
    return b;
  endfunction

  // Message byte, biased toward the stop character and zero.
  function automatic logic [7:0] msg_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return hfr_pkg::STOP_CHAR;
    if (pick < 15) return 8'h00;
    return rand_field();
  endfunction

  // Build a frame around the given message, hashed the way the link does it.
  function automatic void send_frame(logic [7:0] len, logic [7:0] sender,
                                     logic [7:0] rcpt, byte_list_t body,
                                     bit bad_hash);
    byte_list_t  fb;
    logic [15:0] h;
    bit          stopped;
    fb.push_back(hfr_pkg::START_MARK);
    fb.push_back(len);
    fb.push_back(sender);
    fb.push_back(rcpt);
    foreach (body[i]) fb.push_back(body[i]);
    h = 16'h0000;
    stopped = 1'b0;
    foreach (fb[i]) begin
      if (!stopped && i < 4 + int'(len)) begin
        if (fb[i] == 8'h00) stopped = 1'b1;
        else h = 16'((h * 33) ^ fb[i]);
      end
    end
    if (bad_hash) h = h ^ (16'h0001 << $urandom_range(0, 15));
    fb.push_back(h[7:0]);
    fb.push_back(h[15:8]);
    fb.push_back(hfr_pkg::END_MARK);
    foreach (fb[i]) push_byte(fb[i]);
  endfunction

  // Transfer tracking, result checking and register shadowing at the rising edge.
  always @(posedge clk) begin : monitor
    frame_result_t got;
    frame_result_t want;
    link_fired <= rst_n && in_valid && !in_stall;
    report_fired <= rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      rx_collecting = 1'b0;
      rx_index = 6'd0;
      rx_len = 8'h00;
      rx_sender = 8'h00;
      rx_rcpt = 8'h00;
      rx_hash = 16'h0000;
      rx_hash_off = 1'b0;
      rx_got_hash = 16'h0000;
      id_own = 8'h00;
      id_bcast = 8'hFF;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == hfr_pkg::CFG_OWN_ID) id_own = cfg_data;
        else id_bcast = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = {out_status, out_sender, out_msg_code, out_content_byte,
               out_content_valid, out_last};
        if (due_reports.size() == 0) begin
          log_error($sformatf("unexpected result: %s", show(got)));
        end else begin
          want = due_reports.pop_front();
          if (got !== want)
            log_error($sformatf("result mismatch: expected %s, got %s",
                                show(want), show(got)));
        end
      end
      if (in_valid && !in_stall) begin
        track_link_byte(in_rx_byte);
        bytes_taken++;
      end
    end
  end

  // Link driver: offers queued bytes, holding each one until its transfer.
  always @(negedge clk) begin : link_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || link_fired) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (link_bytes.size() != 0) begin
        in_rx_byte <= link_bytes.pop_front();
        in_valid <= 1'b1;
        send_wait = draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each transfer, plus the long hold.
  always @(negedge clk) begin : result_sink
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (report_fired) recv_wait = draw_wait(recv_quiet);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One long receiver hold-off mid-run so the block backs up into the link.
  always @(negedge clk) begin : long_hold
    if (!hold_used && bytes_taken >= HOLD_AFTER) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stimulus: reset, then per phase a register setting and a batch of frames.
  initial begin : stimulus
    byte_list_t body;
    logic [7:0] len;
    logic [7:0] rcpt;
    logic [7:0] own;
    logic [7:0] bcast;
    int         pick;
    int         body_len;
    bit         bad_hash;
    int         goal;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      own = OWN_TBL[ph];
      bcast = BCAST_TBL[ph];
      if (ph != 0) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= hfr_pkg::CFG_OWN_ID;
        cfg_data <= own;
        @(negedge clk);
        cfg_index <= hfr_pkg::CFG_BCAST_ID;
        cfg_data <= bcast;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
      end
      @(posedge clk);
      if (ph == 0) begin
        // Noise while hunting, including a stray end mark.
        push_byte(8'h00);
        push_byte(hfr_pkg::END_MARK);
        // End mark before the length byte.
        push_byte(hfr_pkg::START_MARK);
        push_byte(hfr_pkg::END_MARK);
        // Empty broadcast message; the start value serves as the recipient.
        body.delete();
        send_frame(8'd0, 8'h00, 8'hFF, body, 1'b0);
        // Zero byte freezes the hash and the stop character ends the content.
        body = '{8'h80, 8'h00, hfr_pkg::STOP_CHAR, 8'h7F};
        send_frame(8'd4, 8'hFF, 8'h00, body, 1'b0);
        // Addressed to another station.
        body = '{8'hFF};
        send_frame(8'd1, 8'h55, 8'h42, body, 1'b0);
      end
      goal = bytes_pushed + PHASE_BYTES;
      while (bytes_pushed < goal) begin
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(13, 25))
                                          : 8'($urandom_range(0, 12));
        rcpt = $urandom_range(0, 1) ? own : bcast;
        body_len = int'(len);
        bad_hash = 1'b0;
        if (pick < 10) begin
          bad_hash = 1'b1;
        end else if (pick < 18) begin
          do rcpt = rand_field(); while (rcpt == own || rcpt == bcast);
        end else if (pick < 27) begin
          // Declared length disagrees with the bytes actually sent.
          if ($urandom_range(0, 3) == 0) begin
            do len = 8'($urandom_range(26, 255)); while (len == hfr_pkg::END_MARK);
            body_len = $urandom_range(0, 6);
          end else if (len == 0 || $urandom_range(0, 1) == 1) begin
            body_len = int'(len) + 1;
          end else begin
            body_len = int'(len) - 1;
          end
        end else if (pick < 31) begin
          // Frame that never ends and runs past the buffer.
          push_byte(hfr_pkg::START_MARK);
          repeat (FRAME_CAP - 1) push_byte(msg_byte());
          continue;
        end else if (pick < 37) begin
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
          continue;
        end
        body.delete();
        repeat (body_len) body.push_back(msg_byte());
        send_frame(len, rand_field(), rcpt, body, bad_hash);
      end
      // Close any frame left open so the block hunts before the next setting.
      push_byte(hfr_pkg::END_MARK);
      while (bytes_taken != bytes_pushed || due_reports.size() != 0) @(negedge clk);
      repeat (6) @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (due_reports.size() != 0)
      log_error($sformatf("%0d results never arrived", due_reports.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hfr_pkg.sv
rtl/hfr_datapath.sv
rtl/hfr_ctrl.sv
rtl/hashed_frame_receiver.sv
rtl/hfr_checker.sv
dv/tb_hashed_frame_receiver.sv
